// ===== hdl/udw_pkg.sv =====
package udw_pkg;

    // Ring depth must stay a power of two: slot arithmetic wraps by truncation.
    localparam int MAX_SPANS       = 64;
    localparam int TIME_BITS       = 48;
    localparam int SHARE_FRAC_BITS = 8;

    localparam int IDX_W  = $clog2(MAX_SPANS);
    localparam int CNT_W  = $clog2(MAX_SPANS + 1);
    localparam int THR_W  = SHARE_FRAC_BITS + 1;
    localparam int SUM_W  = TIME_BITS + IDX_W;
    localparam int PROD_W = THR_W + SUM_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TIME_BITS;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 1;
    localparam int OUT_FLD_W  = 5 + CNT_W;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_THRESHOLD = CFG_IDX_W'(2);

    localparam logic [TIME_BITS-1:0] STALL_LIMIT_RST    = TIME_BITS'(180000000);
    localparam logic [TIME_BITS-1:0] WINDOW_LENGTH_RST  = TIME_BITS'(300000000);
    localparam logic [THR_W-1:0]     DUTY_THRESHOLD_RST = THR_W'(192);

    localparam logic [1:0] REPORT_IDLE    = 2'd0;
    localparam logic [1:0] REPORT_WAITING = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_MULT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic mult;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic changed;
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/unsettled_duty_watchdog_core.sv =====
// Unsettled-duty watchdog core.
// The input stream carries one request per status report or time check. s_tuser holds the
// function bit (0 status report, 1 time check) and s_tdata holds the reported state and the
// timestamp. The result stream returns exactly one request per input request, in order.
// A request that does not change the settled flag goes from acceptance straight to the
// finish state. A request that changes the flag writes a new interval into the 64-entry
// history ring and then walks every held interval through the ring's single read port,
// one entry per cycle, summing durations and finding the eviction point in the same pass.
// A drain state and a multiply state follow the walk, then the finish state, which loads
// the result into the output register once that register is free. One request is
// processed at a time: the next request is accepted only after the previous one finishes.
// The result sits in an output register; the next input request is accepted while that
// result waits, and a stalled receiver only holds the following result back.
// A synchronous active-low reset marks the flag settled, disarms the stall timer, empties
// the ring and loads the default configuration. The configuration port writes one register
// per cycle while cfg_wr_en is high and should only be used while the block is idle.
module unsettled_duty_watchdog_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [udw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [udw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0 up: report_state[1:0], now_time[49:2], zero padding.
    input  logic [udw_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser fields from bit 0 up: func[0].
    input  logic [udw_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata fields from bit 0 up: fatal_stall[0], fatal_duty[1], settled_now[2],
    // flag_changed[3], held_intervals[10:4], ring_overflow[11], zero padding.
    output logic [udw_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import udw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences accept, ring walk, multiply and result load.
    udw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the flag, the timer, the ring and the output register.
    udw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tready  (m_tready)
    );

endmodule

// ===== hdl/udw_ctrl.sv =====
module udw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  udw_pkg::dp_status_t status,
    output udw_pkg::dp_cmd_t    cmd
);
    import udw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.changed ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/udw_datapath.sv =====
module udw_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [udw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [udw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [udw_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic [udw_pkg::IN_USER_W-1:0]        s_tuser,
    input  udw_pkg::dp_cmd_t                     cmd,
    output udw_pkg::dp_status_t                  status,
    output logic                                 m_tvalid,
    output logic [udw_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                 m_tready
);
    import udw_pkg::*;

    // Configuration registers.
    logic [TIME_BITS-1:0] stall_limit_reg;
    logic [TIME_BITS-1:0] window_length_reg;
    logic [THR_W-1:0]     duty_threshold_reg;

    // Watchdog state.
    logic                 settled_reg;
    logic                 armed_reg;
    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] last_change_reg;
    logic [IDX_W-1:0]     newest_reg;
    logic [CNT_W-1:0]     count_reg;

    // Per-item results.
    logic                 fstall_reg;
    logic                 changed_reg;
    logic                 ovf_reg;
    logic                 span_unset_reg;

    // Ring memory: unsettled bit above the duration.
    logic [TIME_BITS:0]   span_mem [MAX_SPANS];
    logic [TIME_BITS:0]   rd_data_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_k_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     rd_addr;

    // Walk accumulators.
    logic [SUM_W-1:0]     total_reg;
    logic [SUM_W-1:0]     unset_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     evict_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 ge_reg;

    logic                 out_valid_reg;
    logic [OUT_FLD_W-1:0] out_data_reg;

    logic                 func;
    logic [1:0]           rep;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] dl_diff;
    logic                 fire;
    logic                 armed_mid;
    logic                 to_settled;
    logic                 to_unsettled;
    logic                 changed;
    logic                 ring_full;
    logic [CNT_W-1:0]     count_inc;
    logic [IDX_W-1:0]     slot_new;
    logic [SUM_W-1:0]     prefix;
    logic [PROD_W-1:0]    unset_scaled;
    logic                 fduty;
    logic [CNT_W-1:0]     held_count;

    assign func     = s_tuser[0];
    assign rep      = s_tdata[1:0];
    assign now_time = s_tdata[2 +: TIME_BITS];

    always_comb begin
        // The deadline is reached once the wrapped difference falls in the lower half.
        dl_diff      = now_time - deadline_reg;
        fire         = armed_reg && !dl_diff[TIME_BITS-1];
        armed_mid    = armed_reg && !fire;
        to_settled   = !func && (rep == REPORT_IDLE) && !settled_reg;
        to_unsettled = !func && (rep == REPORT_WAITING) && settled_reg;
        changed      = to_settled || to_unsettled;
        ring_full    = (count_reg == CNT_W'(MAX_SPANS));
        count_inc    = ring_full ? count_reg : count_reg + CNT_W'(1);
        slot_new     = newest_reg + IDX_W'(1);
        rd_addr      = newest_reg - k_reg;
        prefix       = total_reg + SUM_W'(rd_data_reg[TIME_BITS-1:0]);
        unset_scaled = PROD_W'(unset_reg) << SHARE_FRAC_BITS;
        fduty        = changed_reg && span_unset_reg && ge_reg && (unset_scaled > prod_reg);
        held_count   = changed_reg ? evict_cnt_reg : count_reg;
    end

    assign status.changed   = changed;
    assign status.walk_last = ({1'b0, k_reg} == count_reg - CNT_W'(1));
    assign status.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_limit_reg    <= STALL_LIMIT_RST;
            window_length_reg  <= WINDOW_LENGTH_RST;
            duty_threshold_reg <= DUTY_THRESHOLD_RST;
            settled_reg        <= 1'b1;
            armed_reg          <= 1'b0;
            deadline_reg       <= '0;
            last_change_reg    <= '0;
            newest_reg         <= '0;
            count_reg          <= '0;
            rd_vld_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STALL_LIMIT:    stall_limit_reg    <= cfg_wdata;
                    REG_WINDOW_LENGTH:  window_length_reg  <= cfg_wdata;
                    REG_DUTY_THRESHOLD: duty_threshold_reg <= cfg_wdata[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load) begin
                if (to_settled) begin
                    settled_reg <= 1'b1;
                    armed_reg   <= 1'b0;
                end else if (to_unsettled) begin
                    settled_reg <= 1'b0;
                    armed_reg   <= 1'b1;
                    if (!armed_mid) begin
                        deadline_reg <= now_time + stall_limit_reg;
                    end
                end else begin
                    armed_reg <= armed_mid;
                end
                if (changed) begin
                    newest_reg      <= slot_new;
                    last_change_reg <= now_time;
                    count_reg       <= count_inc;
                end
            end
            if (cmd.finish && changed_reg) begin
                count_reg <= evict_cnt_reg;
            end
            rd_vld_reg <= cmd.issue;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && changed) begin
            span_mem[slot_new] <= {to_settled, now_time - last_change_reg};
        end
        rd_data_reg <= span_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        rd_k_reg <= k_reg;
        if (cmd.load) begin
            fstall_reg     <= fire;
            changed_reg    <= changed;
            ovf_reg        <= changed && ring_full;
            span_unset_reg <= to_settled;
            k_reg          <= '0;
            total_reg      <= '0;
            unset_reg      <= '0;
            found_reg      <= 1'b0;
            evict_cnt_reg  <= count_inc;
        end else begin
            if (cmd.issue) begin
                k_reg <= k_reg + IDX_W'(1);
            end
            if (rd_vld_reg) begin
                total_reg <= prefix;
                if (rd_data_reg[TIME_BITS]) begin
                    unset_reg <= unset_reg + SUM_W'(rd_data_reg[TIME_BITS-1:0]);
                end
                if (!found_reg && (prefix > SUM_W'(window_length_reg))) begin
                    found_reg     <= 1'b1;
                    evict_cnt_reg <= CNT_W'(rd_k_reg);
                end
            end
        end
        if (cmd.mult) begin
            prod_reg <= PROD_W'(duty_threshold_reg) * PROD_W'(total_reg);
            ge_reg   <= (total_reg >= SUM_W'(window_length_reg));
        end
        if (cmd.finish) begin
            out_data_reg <= {ovf_reg, held_count, changed_reg, settled_reg, fduty, fstall_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule
